FILE: hw/rtl/heightmap_neighbour_occlusion_defines.svh
// Assertion helpers shared by the checker
`ifndef HEIGHTMAP_NEIGHBOUR_OCCLUSION_DEFINES_SVH
`define HEIGHTMAP_NEIGHBOUR_OCCLUSION_DEFINES_SVH

// Assert that an antecedent implies a consequent on the same edge
`define HNO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hno check failed");

// Assert that an antecedent implies a consequent on the next edge
`define HNO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hno check failed");

`endif

FILE: hw/rtl/hno_pkg.sv
package hno_pkg;
  localparam int unsigned Radius     = 4;
  localparam int unsigned MaxColumns = 256;
  localparam int unsigned MaxRows    = 256;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned AddrW      = ColW + RowW;
  localparam int unsigned Window     = 2 * Radius;
  localparam int unsigned OffW       = $clog2(Window);
  localparam int unsigned CntW       = $clog2(Window * Window);
  localparam int unsigned SumW       = 16 + CntW;
  localparam int unsigned NumW       = 16 + 8 + CntW;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegRows  = 2'd1;
  localparam logic [1:0] RegLimit = 2'd2;
  localparam logic [1:0] RegScale = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [ColW-1:0]  pos_x;
    logic [RowW-1:0]  pos_y;
    logic [15:0]      sample;
    logic [7:0]       in_red;
    logic [7:0]       in_green;
    logic [7:0]       in_blue;
  } req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       darkened;
  } res_t;

  typedef enum logic [3:0] {
    StIdle, StCentre, StCentreWait, StScan, StScanLast, StTest, StMul1, StMul2,
    StDiv, StApply, StOut
  } back_st_e;
endpackage

FILE: hw/rtl/heightmap_neighbour_occlusion.sv
// Height map neighbour occlusion.
// Slave stream: s_axis_tuser = kind (0 load, 1 query); s_axis_tdata holds
// pos_x, pos_y, sample, in_red, in_green, in_blue from the lowest bit up.
// Master stream: m_axis_tdata holds out_red, out_green, out_blue, darkened.
// Configuration: cfg_we_i writes register cfg_idx_i (width, rows, limit,
// scale) with cfg_wdata_i at the rising edge.
// Loads are written into a 64K x 16 map in the cycle they are taken and
// give no result; a load is taken only when no query is queued or in the
// back end. Queries wait in a four entry queue; the back end reads the
// centre and, if it is at or above the limit, the 64, 32 or 16 window
// positions one per cycle on the single map read port, then for a darkened
// result runs a bit per cycle divide.
// The back end takes the next query only once the last one has reached the
// output register. Reset clears the queue and back end; the map content is
// undefined until loaded. A stalled master holds the result; the back end
// stops at its next result and the queue then fills and lowers s_axis_tready.
module heightmap_neighbour_occlusion (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // pos_x, pos_y, sample, in_red, in_green, in_blue
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_red, out_green, out_blue, darkened, zero pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import hno_pkg::*;

  req_t             in_req, q_req;
  res_t             res;
  logic             map_we, q_valid, q_pop, busy;
  logic [AddrW-1:0] map_waddr, map_raddr;
  logic [15:0]      map_wdata, map_rdata;
  logic [8:0]       width_q, rows_q;
  logic [15:0]      limit_q;
  logic [7:0]       scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd256;
      rows_q  <= 9'd256;
      limit_q <= '0;
      scale_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth: width_q <= cfg_wdata_i[8:0];
        RegRows:  rows_q  <= cfg_wdata_i[8:0];
        RegLimit: limit_q <= cfg_wdata_i;
        RegScale: scale_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_req.kind     = s_axis_tuser;
    in_req.pos_x    = s_axis_tdata[7:0];
    in_req.pos_y    = s_axis_tdata[15:8];
    in_req.sample   = s_axis_tdata[31:16];
    in_req.in_red   = s_axis_tdata[39:32];
    in_req.in_green = s_axis_tdata[47:40];
    in_req.in_blue  = s_axis_tdata[55:48];
  end

  hno_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_req_i(in_req),
    .map_we_o(map_we), .map_waddr_o(map_waddr), .map_wdata_o(map_wdata),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req), .back_busy_i(busy)
  );

  hno_ram #(.Width(16), .Depth(MaxRows * MaxColumns)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .raddr_i(map_raddr), .rdata_o(map_rdata)
  );

  hno_back u_back (
    .clk_i, .rst_ni,
    .map_width_i(width_q), .map_rows_i(rows_q),
    .shade_limit_i(limit_q), .shade_scale_i(scale_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .map_raddr_o(map_raddr), .map_rdata_i(map_rdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res),
    .busy_o(busy)
  );

  assign m_axis_tdata = {7'd0, res.darkened, res.out_blue, res.out_green, res.out_red};
endmodule

FILE: hw/rtl/hno_ram.sv
module hno_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hw/rtl/hno_front.sv
module hno_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hno_pkg::req_t in_req_i,
  output logic          map_we_o,
  output logic [hno_pkg::AddrW-1:0] map_waddr_o,
  output logic [15:0]   map_wdata_o,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output hno_pkg::req_t q_req_o,
  input  logic          back_busy_i
);
  import hno_pkg::*;

  req_t              fifo_q [QueueDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]    cnt_q, cnt_d;
  logic              acc, push;

  // a load may only bypass the queue when no query is pending or in progress
  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = (cnt_q != (QPtrW+1)'(QueueDepth)) &&
                      (in_req_i.kind == KindQuery || (cnt_q == '0 && !back_busy_i));
  assign push       = acc && in_req_i.kind == KindQuery;
  assign map_we_o    = acc && in_req_i.kind == KindLoad;
  assign map_waddr_o = {in_req_i.pos_y, in_req_i.pos_x};
  assign map_wdata_o = in_req_i.sample;
  assign q_valid_o   = cnt_q != '0;
  assign q_req_o     = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = q_pop_i ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= in_req_i;
    end
  end
endmodule

FILE: hw/rtl/hno_back.sv
module hno_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [8:0]    map_width_i,
  input  logic [8:0]    map_rows_i,
  input  logic [15:0]   shade_limit_i,
  input  logic [7:0]    shade_scale_i,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  hno_pkg::req_t q_req_i,
  output logic [hno_pkg::AddrW-1:0] map_raddr_o,
  input  logic [15:0]   map_rdata_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hno_pkg::res_t out_res_o,
  output logic          busy_o
);
  import hno_pkg::*;

  back_st_e          st_q, st_d;
  req_t              req_q;
  logic [15:0]       h_q;
  logic [OffW-1:0]   ix_q, ix_d, iy_q, iy_d;
  logic [OffW-1:0]   nx, ny;
  logic              xfull_q, xneg_q, yfull_q, yneg_q;
  logic              xfull, xneg, yfull, yneg;
  logic [OffW-1:0]   xend, yend;
  logic              rd_take_q, rd_take_d;
  logic [SumW-1:0]   sum_q;
  logic [CntW:0]     cnt_q;
  logic [NumW-1:0]   num_q, rem_q;
  logic [NumW-1:0]   quo_q;
  logic [$clog2(NumW+1)-1:0] bit_q;
  logic [NumW:0]     trial;
  logic [7:0]        dec;
  logic              dark_q;
  res_t              res_q;
  logic              ov_q;
  logic signed [9:0] dxs, dys;
  logic              cskip, last_cell;

  // window shape per axis
  always_comb begin
    xneg  = {1'b0, q_req_i.pos_x} >= 9'(Radius) &&
            $signed({2'b0, q_req_i.pos_x}) >=
            $signed({1'b0, map_width_i}) - $signed(10'(Radius));
    xfull = {1'b0, q_req_i.pos_x} >= 9'(Radius) && !xneg;
    yneg  = {1'b0, q_req_i.pos_y} >= 9'(Radius) &&
            $signed({2'b0, q_req_i.pos_y}) >=
            $signed({1'b0, map_rows_i}) - $signed(10'(Radius));
    yfull = {1'b0, q_req_i.pos_y} >= 9'(Radius) && !yneg;
  end

  assign xend = xfull_q ? OffW'(Window - 1) : OffW'(Radius - 1);
  assign yend = yfull_q ? OffW'(Window - 1) : OffW'(Radius - 1);

  always_comb begin
    dxs = (xfull_q || xneg_q) ? $signed(10'(ix_q)) - $signed(10'(Radius)) :
                                $signed(10'(ix_q));
    dys = (yfull_q || yneg_q) ? $signed(10'(iy_q)) - $signed(10'(Radius)) :
                                $signed(10'(iy_q));
    cskip = dxs == 10'sd0 && dys == 10'sd0;
    last_cell = ix_q == xend && iy_q == yend;
    nx = ix_q == xend ? '0 : ix_q + OffW'(1);
    ny = ix_q == xend ? iy_q + OffW'(1) : iy_q;
  end

  always_comb begin
    map_raddr_o = {req_q.pos_y, req_q.pos_x};
    if (st_q == StScan) begin
      map_raddr_o = {RowW'($signed({2'b0, req_q.pos_y}) + dys),
                     ColW'($signed({2'b0, req_q.pos_x}) + dxs)};
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:       if (q_valid_i) st_d = StCentre;
      StCentre:     st_d = StCentreWait;
      StCentreWait: st_d = StTest;
      StScan:       if (last_cell) st_d = StScanLast;
      StScanLast:   st_d = StMul1;
      StTest:       st_d = (h_q >= shade_limit_i) ? StScan : StOut;
      StMul1:       st_d = StMul2;
      StMul2:       st_d = dark_q ? StDiv : StOut;
      StDiv:        if (bit_q == '0) st_d = StApply;
      StApply:      st_d = StOut;
      StOut:        if (!ov_q) st_d = StIdle;
      default:      st_d = StIdle;
    endcase
  end

  always_comb begin
    q_pop_o   = st_q == StIdle && q_valid_i;
    ix_d      = ix_q;
    iy_d      = iy_q;
    rd_take_d = 1'b0;
    if (st_q == StScan) begin
      ix_d      = nx;
      iy_d      = ny;
      rd_take_d = !cskip;
    end
  end

  assign trial = {rem_q, num_q[NumW-1]} - {1'b0, NumW'(sum_q)};
  assign dec   = (quo_q + NumW'(rem_q != '0) > NumW'(255)) ? 8'hFF :
                 8'(quo_q + NumW'(rem_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      ov_q      <= 1'b0;
      rd_take_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      rd_take_q <= rd_take_d;
      if (st_q == StOut && !ov_q) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        req_q   <= q_req_i;
        xfull_q <= xfull;
        xneg_q  <= xneg;
        yfull_q <= yfull;
        yneg_q  <= yneg;
        ix_q    <= '0;
        iy_q    <= '0;
        sum_q   <= '0;
        cnt_q   <= '0;
        dark_q  <= 1'b0;
      end
      StCentreWait: h_q <= map_rdata_i;
      StScan: begin
        ix_q <= ix_d;
        iy_q <= iy_d;
        if (!cskip) cnt_q <= cnt_q + (CntW+1)'(1);
      end
      StMul1: begin
        num_q  <= NumW'(h_q) * NumW'(shade_scale_i);
        dark_q <= NumW'(h_q) * NumW'(cnt_q) < NumW'(sum_q);
      end
      StMul2: begin
        num_q  <= NumW'(num_q[23:0]) * NumW'(cnt_q);
        rem_q  <= '0;
        quo_q  <= '0;
        bit_q  <= ($clog2(NumW+1))'(NumW);
      end
      StDiv: begin
        if (bit_q != '0) begin
          bit_q <= bit_q - ($clog2(NumW+1))'(1);
          num_q <= {num_q[NumW-2:0], 1'b0};
          if (!trial[NumW]) begin
            rem_q <= trial[NumW-1:0];
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_q <= {rem_q[NumW-2:0], num_q[NumW-1]};
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
        end
      end
      StOut: begin
        if (!ov_q) begin
          res_q.darkened  <= dark_q;
          res_q.out_red   <= (dark_q && req_q.in_red   <= dec) ? 8'd0 :
                             dark_q ? req_q.in_red - dec : req_q.in_red;
          res_q.out_green <= (dark_q && req_q.in_green <= dec) ? 8'd0 :
                             dark_q ? req_q.in_green - dec : req_q.in_green;
          res_q.out_blue  <= (dark_q && req_q.in_blue  <= dec) ? 8'd0 :
                             dark_q ? req_q.in_blue - dec : req_q.in_blue;
        end
      end
      default: ;
    endcase
    if (rd_take_q) begin
      sum_q <= sum_q + SumW'(map_rdata_i);
    end
  end

  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;
  assign busy_o      = st_q != StIdle;
endmodule

FILE: hw/rtl/hno_checker.sv
`include "heightmap_neighbour_occlusion_defines.svh"

module hno_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  `HNO_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata))
  `HNO_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:25] == 7'd0)
  `HNO_ASSERT_IMP(a_ready_known, clk_i, rst_ni, s_axis_tvalid, !$isunknown(s_axis_tready))
  `HNO_ASSERT_NXT(a_gap, clk_i, rst_ni, m_axis_tvalid && m_axis_tready,
                  !m_axis_tvalid)
endmodule

bind heightmap_neighbour_occlusion hno_checker u_hno_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
